>>> sv/jadm_pkg.sv
// Shared types and constants for the joystick axis dead-band mapper.
// No dependencies; every other file but jadm_ifs imports this package.
`timescale 1ns / 1ps

package jadm_pkg;

	// Fixed raw and user scale points
	localparam logic [9:0]        CentreRaw = 10'd512;
	localparam logic signed [7:0] UserMax   = 8'sh7f;
	localparam logic signed [7:0] UserMin   = 8'sh80;

	// Magnitude divider: 17-bit dividend, one quotient bit per cycle
	localparam int DivSteps = 17;
	localparam int DivBits  = $clog2(DivSteps);

	// Register indexes (byte address / 4)
	localparam logic [2:0] RegCentreWidth = 3'd0;
	localparam logic [2:0] RegHysteresis  = 3'd1;
	localparam logic [2:0] RegEdgePlateau = 3'd2;
	localparam logic [2:0] RegAxisMin     = 3'd3;
	localparam logic [2:0] RegAxisMax     = 3'd4;

	// Reset values
	localparam logic [8:0] RstCentreWidth = 9'd40;
	localparam logic [7:0] RstHysteresis  = 8'd4;
	localparam logic [7:0] RstEdgePlateau = 8'd20;
	localparam logic [8:0] RstAxisMin     = 9'd0;
	localparam logic [9:0] RstAxisMax     = 10'd1023;

	typedef struct packed {
		logic [8:0] centre_plateau_width;
		logic [7:0] hysteresis;
		logic [7:0] edge_plateau;
		logic [8:0] axis_min;
		logic [9:0] axis_max;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_FIN
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic cap;     // latch incoming sample
		logic eval;    // snap, hysteresis test, set up divider
		logic step;    // one divider iteration
		logic commit;  // load output register, update last user value
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic accept;  // valid during eval
		logic direct;  // valid during eval: no division needed
		logic changed; // valid during finish
	} sts_t;

endpackage

>>> sv/jadm_ifs.sv
// Stream interfaces for the sample input and the user value output.
// Depends on nothing.
`timescale 1ns / 1ps

interface jadm_sample_if;
	logic       valid;
	logic       ready;
	logic [9:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface jadm_value_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] axis_value;

	modport source (output valid, output axis_value, input ready);
	modport sink   (input valid, input axis_value, output ready);
endinterface

>>> sv/joystick_axis_deadband_mapper.sv
// Joystick axis dead-band mapper, top level: config registers, controller, datapath.
// Depends on jadm_pkg, jadm_ifs, jadm_regs, jadm_ctrl, jadm_dp.
// One 10-bit ADC sample is taken at a time. A sample rejected by the
// hysteresis test passes through accept and eval only; a sample at centre or
// with a zero span passes through accept, eval and finish; a sample that needs
// the linear map passes through accept, eval, 17 iterations of the
// one-bit-per-cycle magnitude divider, and finish. A new sample is taken as
// soon as the previous one is finished, even while its result still sits in
// the output register; the finish step only stalls if that register is still
// full. A result leaves only when the mapped value changes.
`timescale 1ns / 1ps

module joystick_axis_deadband_mapper
	import jadm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	jadm_sample_if.sink   sample,
	jadm_value_if.source  value,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// Registers at byte address 4*i; writes to unused indexes are dropped
	jadm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer; also holds output valid
	jadm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (value.valid),
		.out_ready (value.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// last_raw / last_user live here along with the divider
	jadm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.adc_sample (sample.adc_sample),
		.sts        (sts),
		.axis_value (value.axis_value)
	);

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!value.valid || value.ready))
		else $error("result committed into full output register");

	// A commit always presents a result next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> value.valid)
		else $error("committed result not presented");

	// One item in flight: after acceptance the input closes
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("second item taken while one is in progress");

	// Commit only after finishing the evaluation of an item
	a_commit_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !cmd.eval && !cmd.step && !sample.ready)
		else $error("commit outside finish step");

endmodule

>>> sv/jadm_regs.sv
// APB-style configuration register file.
// Depends on jadm_pkg.
`timescale 1ns / 1ps

module jadm_regs
	import jadm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_plateau_width <= RstCentreWidth;
			cfg_q.hysteresis           <= RstHysteresis;
			cfg_q.edge_plateau         <= RstEdgePlateau;
			cfg_q.axis_min             <= RstAxisMin;
			cfg_q.axis_max             <= RstAxisMax;
		end else if (wr_en) begin
			case (idx)
				RegCentreWidth: cfg_q.centre_plateau_width <= pwdata[8:0];
				RegHysteresis:  cfg_q.hysteresis           <= pwdata[7:0];
				RegEdgePlateau: cfg_q.edge_plateau         <= pwdata[7:0];
				RegAxisMin:     cfg_q.axis_min             <= pwdata[8:0];
				RegAxisMax:     cfg_q.axis_max             <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RegCentreWidth: prdata = {23'd0, cfg_q.centre_plateau_width};
			RegHysteresis:  prdata = {24'd0, cfg_q.hysteresis};
			RegEdgePlateau: prdata = {24'd0, cfg_q.edge_plateau};
			RegAxisMin:     prdata = {23'd0, cfg_q.axis_min};
			RegAxisMax:     prdata = {22'd0, cfg_q.axis_max};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

>>> sv/jadm_dp.sv
// Datapath: dead-zone snap, hysteresis test, span setup, serial divider,
// clamp and output register. Depends on jadm_pkg.
`timescale 1ns / 1ps

module jadm_dp
	import jadm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	input  logic [9:0]        adc_sample,
	output sts_t              sts,
	output logic signed [7:0] axis_value
);

	// control state
	logic [9:0]        last_raw_q;
	logic signed [7:0] last_user_q;

	// payload
	logic [9:0]        smp_q;
	logic              below_q;
	logic              neg_q;
	logic              direct_q;
	logic signed [7:0] dval_q;
	logic [16:0]       quo_q;
	logic [9:0]        rem_q;
	logic [9:0]        dvs_q;
	logic signed [7:0] out_q;

	// eval stage
	logic [7:0]         half;
	logic [9:0]         clo, chi, v_c;
	logic               snap, acc;
	logic               above, below;
	logic [10:0]        v_ext, last_ext, lo_dn;
	logic signed [11:0] hi_up, span_up, diff_up, span_dn, diff_dn, span, diff;
	logic signed [18:0] diff_x, num;
	logic signed [18:0] num_abs;
	logic signed [11:0] span_abs;
	logic               direct;
	logic signed [7:0]  dval;

	// divider step
	logic [10:0] sh, sh_sub;
	logic        ge;

	// finish
	logic signed [18:0] q_c, sum_c;
	logic signed [7:0]  clamp_c, mapped_c;

	always_comb begin
		half  = cfg.centre_plateau_width[8:1];
		clo   = CentreRaw - {2'd0, half};
		chi   = CentreRaw + {2'd0, half};
		snap  = (smp_q > clo) && (smp_q < chi);
		v_c   = snap ? CentreRaw : smp_q;

		v_ext    = {1'b0, v_c};
		last_ext = {1'b0, last_raw_q};
		acc = (v_ext > last_ext + {3'd0, cfg.hysteresis})
			|| (v_ext + {3'd0, cfg.hysteresis} < last_ext)
			|| (v_c == CentreRaw && last_raw_q != CentreRaw)
			|| (v_c == {1'b0, cfg.axis_min} && last_raw_q != {1'b0, cfg.axis_min})
			|| (v_c == cfg.axis_max && last_raw_q != cfg.axis_max);

		above = v_c > CentreRaw;
		below = v_c < CentreRaw;

		// upper half: lo = centre + half, hi = axis_max - edge
		hi_up   = $signed({2'd0, cfg.axis_max}) - $signed({4'd0, cfg.edge_plateau});
		span_up = hi_up - $signed({2'd0, chi});
		diff_up = $signed({2'd0, v_c}) - $signed({2'd0, chi});
		// lower half: lo = axis_min + edge, hi = centre - half
		lo_dn   = {2'd0, cfg.axis_min} + {3'd0, cfg.edge_plateau};
		span_dn = $signed({2'd0, clo}) - $signed({1'b0, lo_dn});
		diff_dn = $signed({2'd0, v_c}) - $signed({1'b0, lo_dn});

		span   = below ? span_dn : span_up;
		diff   = below ? diff_dn : diff_up;
		diff_x = {{7{diff[11]}}, diff};
		// *128 below, *127 above
		num    = below ? (diff_x <<< 7) : ((diff_x <<< 7) - diff_x);

		num_abs  = num[18] ? -num : num;
		span_abs = span[11] ? -span : span;

		direct = !above && !below || (span == 12'sd0);
		if (!above && !below)
			dval = 8'sd0;
		else if (below)
			dval = UserMin;
		else
			dval = UserMax;
	end

	assign sh     = {rem_q, quo_q[16]};
	assign sh_sub = sh - {1'b0, dvs_q};
	assign ge     = sh >= {1'b0, dvs_q};

	always_comb begin
		q_c   = neg_q ? -$signed({2'd0, quo_q}) : $signed({2'd0, quo_q});
		sum_c = q_c + (below_q ? -19'sd128 : 19'sd0);
		if (sum_c < -19'sd128)
			clamp_c = UserMin;
		else if (sum_c > 19'sd127)
			clamp_c = UserMax;
		else
			clamp_c = sum_c[7:0];
		mapped_c = direct_q ? dval_q : clamp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= CentreRaw;
			last_user_q <= 8'sd0;
		end else begin
			if (cmd.eval && acc)
				last_raw_q <= v_c;
			if (cmd.commit)
				last_user_q <= mapped_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap)
			smp_q <= adc_sample;
		if (cmd.eval) begin
			below_q  <= below;
			neg_q    <= num[18] ^ span[11];
			direct_q <= direct;
			dval_q   <= dval;
			quo_q    <= num_abs[16:0];
			dvs_q    <= span_abs[9:0];
			rem_q    <= 10'd0;
		end else if (cmd.step) begin
			rem_q <= ge ? sh_sub[9:0] : sh[9:0];
			quo_q <= {quo_q[15:0], ge};
		end
		if (cmd.commit)
			out_q <= mapped_c;
	end

	assign sts.accept  = acc;
	assign sts.direct  = direct;
	assign sts.changed = mapped_c != last_user_q;
	assign axis_value  = out_q;

endmodule

>>> sv/jadm_ctrl.sv
// Controller: sequences one item through eval, divide and finish,
// and owns the output valid flag. Depends on jadm_pkg.
`timescale 1ns / 1ps

module jadm_ctrl
	import jadm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t             state_q, state_d;
	logic [DivBits-1:0] cnt_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (!sts.accept)
					state_d = ST_IDLE;
				else if (sts.direct)
					state_d = ST_FIN;
				else
					state_d = ST_DIV;
			end
			ST_DIV: if (cnt_q == DivBits'(DivSteps - 1)) state_d = ST_FIN;
			ST_FIN: if (!sts.changed || slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			ST_EVAL: cmd.eval = 1'b1;
			ST_DIV:  cmd.step = 1'b1;
			ST_FIN:  cmd.commit = sts.changed && slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL)
				cnt_q <= '0;
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
